>>> src/snc_pkg.sv
// Shared types and constants of the sensor report conditioner.
// No dependencies; every other file refers to this package by scoped names.
package snc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_HIGH      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_LOW       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_DEADBAND  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_DEADBAND   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_DEADBAND = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KEEPALIVE      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_VACANCY        = 3'd6;

  // Reset values of the configuration registers.
  localparam logic signed [14:0] RST_TEMP_HIGH      = 15'sd3500;
  localparam logic signed [14:0] RST_TEMP_LOW       = 15'sd500;
  localparam logic [14:0]        RST_TEMP_DEADBAND  = 15'd50;
  localparam logic [13:0]        RST_HUM_DEADBAND   = 14'd200;
  localparam logic [15:0]        RST_LIGHT_DEADBAND = 16'd20;
  localparam logic [7:0]         RST_KEEPALIVE      = 8'd6;
  localparam logic [7:0]         RST_VACANCY        = 8'd12;

  // Result kinds.
  localparam logic [1:0] KIND_TEMP_ALERT = 2'd0;
  localparam logic [1:0] KIND_OCC_ALERT  = 2'd1;
  localparam logic [1:0] KIND_REPORT     = 2'd2;

  localparam logic [7:0]  COUNT_MAX   = 8'hFF;
  localparam logic [13:0] ALERT_MAX   = 14'h3FFF;

  typedef struct packed {
    logic signed [14:0] temp_high;
    logic signed [14:0] temp_low;
    logic [14:0]        temp_band;
    logic [13:0]        hum_deadband;
    logic [15:0]        light_band;
    logic [7:0]         keepalive;
    logic [7:0]         vacancy;
  } cfg_regs_t;

  typedef struct packed {
    logic load;
    logic sum_step;
    logic div_init;
    logic div_step;
    logic eval;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic sum_last;
    logic div_last;
    logic emit_done;
  } dp_status_t;

endpackage

>>> src/snc_intf.sv
// Handshake channel interfaces of the sensor report conditioner.
// Depends on snc_pkg for the configuration port widths.
interface snc_sample_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] temperature;
  logic [13:0]        humidity;
  logic [15:0]        light;
  logic               motion;
  modport source (output valid, temperature, humidity, light, motion, input ready);
  modport sink (input valid, temperature, humidity, light, motion, output ready);
endinterface

interface snc_result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [14:0] avg_temperature;
  logic [13:0]        avg_humidity;
  logic [15:0]        avg_light;
  logic               occupied;
  logic [13:0]        alert_value;
  logic               last;
  modport source (output valid, kind, avg_temperature, avg_humidity, avg_light, occupied,
                  alert_value, last, input ready);
  modport sink (input valid, kind, avg_temperature, avg_humidity, avg_light, occupied,
                alert_value, last, output ready);
endinterface

interface snc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [snc_pkg::CFG_IDX_W-1:0]    index;
  logic [snc_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> src/sensor_report_conditioner.sv
// Top level of the sensor report conditioner: configuration registers,
// sequencer and datapath. Depends on snc_pkg, snc_intf, snc_ctrl, snc_datapath.
//
//   channel    role   transaction
//   sample_ch  sink   temperature, humidity, light, motion
//   result_ch  source kind, averages, occupancy, alert value, last
//   cfg_ch     sink   register index and write data, always ready
//
// An item passes through acceptance, window summing over the F samples held
// (F up to WINDOW), restoring dividers over 16 + clog2(WINDOW+1) quotient bits,
// evaluation and emission of one result per cycle while the result output is
// not stalled. With the default WINDOW, the dividers' bit-per-cycle loop takes
// most of the time spent on an item.
// Reset (rst, synchronous) empties the windows and restores register defaults.
// A stalled result output holds the pending results; a new sample may be
// accepted while the last result of the previous one waits.
module sensor_report_conditioner #(
  parameter int WINDOW = 5
) (
  input logic          clk,
  input logic          rst,
  snc_sample_if.sink   sample_ch,
  snc_result_if.source result_ch,
  snc_cfg_if.sink      cfg_ch
);

  snc_pkg::cfg_regs_t  cfg;
  snc_pkg::dp_cmd_t    cmd;
  snc_pkg::dp_status_t status;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.temp_high    <= snc_pkg::RST_TEMP_HIGH;
      cfg.temp_low     <= snc_pkg::RST_TEMP_LOW;
      cfg.temp_band    <= snc_pkg::RST_TEMP_DEADBAND;
      cfg.hum_deadband <= snc_pkg::RST_HUM_DEADBAND;
      cfg.light_band   <= snc_pkg::RST_LIGHT_DEADBAND;
      cfg.keepalive    <= snc_pkg::RST_KEEPALIVE;
      cfg.vacancy      <= snc_pkg::RST_VACANCY;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        snc_pkg::REG_TEMP_HIGH:      cfg.temp_high    <= cfg_ch.data[14:0];
        snc_pkg::REG_TEMP_LOW:       cfg.temp_low     <= cfg_ch.data[14:0];
        snc_pkg::REG_TEMP_DEADBAND:  cfg.temp_band    <= cfg_ch.data[14:0];
        snc_pkg::REG_HUM_DEADBAND:   cfg.hum_deadband <= cfg_ch.data[13:0];
        snc_pkg::REG_LIGHT_DEADBAND: cfg.light_band   <= cfg_ch.data[15:0];
        snc_pkg::REG_KEEPALIVE:      cfg.keepalive    <= cfg_ch.data[7:0];
        snc_pkg::REG_VACANCY:        cfg.vacancy      <= cfg_ch.data[7:0];
        default: ;
      endcase
    end
  end

  snc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample_ch.valid),
    .in_ready (sample_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  snc_datapath #(
    .WINDOW (WINDOW)
  ) u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .status              (status),
    .cfg                 (cfg),
    .in_temperature      (sample_ch.temperature),
    .in_humidity         (sample_ch.humidity),
    .in_light            (sample_ch.light),
    .in_motion           (sample_ch.motion),
    .out_valid           (result_ch.valid),
    .out_ready           (result_ch.ready),
    .out_kind            (result_ch.kind),
    .out_avg_temperature (result_ch.avg_temperature),
    .out_avg_humidity    (result_ch.avg_humidity),
    .out_avg_light       (result_ch.avg_light),
    .out_occupied        (result_ch.occupied),
    .out_alert_value     (result_ch.alert_value),
    .out_last            (result_ch.last)
  );

endmodule

>>> src/snc_ctrl.sv
// Sequencer of the sensor report conditioner: one item at a time through
// load, window sum, division, evaluation and result emission. Uses snc_pkg.
module snc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  snc_pkg::dp_status_t status,
  output snc_pkg::dp_cmd_t    cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SUM   = 6'b000010,
    S_DINIT = 6'b000100,
    S_DIV   = 6'b001000,
    S_EVAL  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        cmd.sum_step = 1'b1;
        if (status.sum_last) state_next = S_DINIT;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (status.emit_done) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> src/snc_datapath.sv
// Datapath: sample windows, running sums, three restoring dividers,
// occupancy debounce, report decision and output register. Uses snc_pkg.
module snc_datapath #(
  parameter int WINDOW = 5
) (
  input  logic                    clk,
  input  logic                    rst,
  input  snc_pkg::dp_cmd_t        cmd,
  output snc_pkg::dp_status_t     status,
  input  snc_pkg::cfg_regs_t      cfg,
  input  logic signed [14:0]      in_temperature,
  input  logic [13:0]             in_humidity,
  input  logic [15:0]             in_light,
  input  logic                    in_motion,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              out_kind,
  output logic signed [14:0]      out_avg_temperature,
  output logic [13:0]             out_avg_humidity,
  output logic [15:0]             out_avg_light,
  output logic                    out_occupied,
  output logic [13:0]             out_alert_value,
  output logic                    out_last
);

  localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;  // slot index width
  localparam int CW = $clog2(WINDOW + 1);                  // fill count width
  localparam int DW = 16 + CW;                             // sum width
  localparam int KW = $clog2(DW + 1);                      // divider step count width
  localparam logic [IW-1:0] LAST_SLOT = IW'(WINDOW - 1);
  localparam logic [CW-1:0] FULL      = CW'(WINDOW);
  localparam logic [KW-1:0] LAST_STEP = KW'(DW - 1);

  logic signed [14:0] temp_window  [WINDOW];
  logic [13:0]        hum_window   [WINDOW];
  logic [15:0]        light_window [WINDOW];

  logic [IW-1:0] window_pointer;
  logic [CW-1:0] window_fill;
  logic [IW-1:0] sum_idx;
  logic          motion;

  logic signed [DW-1:0] temp_sum;
  logic [DW-1:0]        hum_sum;
  logic [DW-1:0]        light_sum;

  logic [DW-1:0] temp_q, hum_q, light_q;
  logic [CW-1:0] temp_rem, hum_rem, light_rem;
  logic          temp_neg;
  logic [KW-1:0] div_cnt;

  logic          occupied_flag, previous_occupied, seen_first, sent_once;
  logic [7:0]    quiet_run, skipped_reports;
  logic signed [14:0] sent_temperature;
  logic [13:0]   sent_humidity;
  logic [15:0]   sent_light;

  logic          pend_temp, pend_occ, pend_rep;
  logic [13:0]   temp_abs;
  logic          out_load;

  // One restoring division step: returns {remainder, quotient}.
  function automatic logic [CW+DW-1:0] div_once(input logic [CW-1:0] rem,
                                                 input logic [DW-1:0] q,
                                                 input logic [CW-1:0] d);
    logic [CW:0] shifted;
    logic        take;
    logic [CW:0] diff;
    shifted = {rem, q[DW-1]};
    take    = (shifted >= {1'b0, d});
    diff    = shifted - {1'b0, d};
    if (take) begin
      return {diff[CW-1:0], q[DW-2:0], 1'b1};
    end else begin
      return {shifted[CW-1:0], q[DW-2:0], 1'b0};
    end
  endfunction

  logic [CW+DW-1:0] temp_step, hum_step, light_step;
  logic [DW-1:0]    temp_mag, temp_q_neg;

  assign temp_step  = div_once(temp_rem, temp_q, window_fill);
  assign hum_step   = div_once(hum_rem, hum_q, window_fill);
  assign light_step = div_once(light_rem, light_q, window_fill);
  assign temp_mag   = temp_sum[DW-1] ? DW'(-temp_sum) : DW'(temp_sum);
  assign temp_q_neg = -temp_q;

  assign status.sum_last  = (CW'(sum_idx) == window_fill - CW'(1));
  assign status.div_last  = (div_cnt == LAST_STEP);
  assign status.emit_done = !(pend_temp || pend_occ || pend_rep);

  // Averages, valid once the division has finished.
  logic signed [14:0] t_avg;
  logic [13:0]        h_avg;
  logic [15:0]        l_avg;
  assign t_avg = temp_neg ? temp_q_neg[14:0] : temp_q[14:0];
  assign h_avg = hum_q[13:0];
  assign l_avg = light_q[15:0];

  // Occupancy debounce and report decision.
  logic [7:0]  quiet_next;
  logic        occ_next, changed, temp_hit, report;
  logic [14:0] t_abs_full;
  logic signed [15:0] t_diff;
  logic [15:0] t_diff_abs;
  logic [13:0] h_diff;
  logic [15:0] l_diff;

  always_comb begin
    if (motion) begin
      quiet_next = '0;
      occ_next   = 1'b1;
    end else begin
      quiet_next = (quiet_run == snc_pkg::COUNT_MAX) ? quiet_run : quiet_run + 8'd1;
      occ_next   = occupied_flag && !(quiet_next >= cfg.vacancy);
    end
    changed    = (occ_next != previous_occupied);
    temp_hit   = (t_avg > cfg.temp_high) || (t_avg < cfg.temp_low);
    t_abs_full = t_avg[14] ? 15'(-t_avg) : 15'(t_avg);
    t_diff     = {t_avg[14], t_avg} - {sent_temperature[14], sent_temperature};
    t_diff_abs = t_diff[15] ? 16'(-t_diff) : 16'(t_diff);
    h_diff     = (h_avg > sent_humidity) ? h_avg - sent_humidity : sent_humidity - h_avg;
    l_diff     = (l_avg > sent_light) ? l_avg - sent_light : sent_light - l_avg;
    report     = changed || !sent_once || (skipped_reports >= cfg.keepalive) ||
                 (t_diff_abs >= {1'b0, cfg.temp_band}) ||
                 (h_diff >= cfg.hum_deadband) || (l_diff >= cfg.light_band);
  end

  // Window storage and sums.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      temp_window[window_pointer]  <= in_temperature;
      hum_window[window_pointer]   <= in_humidity;
      light_window[window_pointer] <= in_light;
      motion    <= in_motion;
      temp_sum  <= '0;
      hum_sum   <= '0;
      light_sum <= '0;
    end else if (cmd.sum_step) begin
      temp_sum  <= temp_sum + {{(DW-15){temp_window[sum_idx][14]}}, temp_window[sum_idx]};
      hum_sum   <= hum_sum + DW'(hum_window[sum_idx]);
      light_sum <= light_sum + DW'(light_window[sum_idx]);
    end
    if (cmd.div_init) begin
      temp_q    <= temp_mag;
      hum_q     <= hum_sum;
      light_q   <= light_sum;
      temp_neg  <= temp_sum[DW-1];
      temp_rem  <= '0;
      hum_rem   <= '0;
      light_rem <= '0;
    end else if (cmd.div_step) begin
      {temp_rem, temp_q}   <= temp_step;
      {hum_rem, hum_q}     <= hum_step;
      {light_rem, light_q} <= light_step;
    end
    if (cmd.eval) begin
      temp_abs <= t_abs_full[14] ? snc_pkg::ALERT_MAX : t_abs_full[13:0];
    end
  end

  // Control and tracking state.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_pointer    <= '0;
      window_fill       <= '0;
      sum_idx           <= '0;
      div_cnt           <= '0;
      occupied_flag     <= 1'b0;
      quiet_run         <= '0;
      previous_occupied <= 1'b0;
      seen_first        <= 1'b0;
      sent_once         <= 1'b0;
      sent_temperature  <= '0;
      sent_humidity     <= '0;
      sent_light        <= '0;
      skipped_reports   <= '0;
      pend_temp         <= 1'b0;
      pend_occ          <= 1'b0;
      pend_rep          <= 1'b0;
    end else begin
      if (cmd.load) begin
        window_pointer <= (window_pointer == LAST_SLOT) ? '0 : window_pointer + 1'b1;
        if (window_fill != FULL) window_fill <= window_fill + 1'b1;
        sum_idx <= '0;
      end else if (cmd.sum_step) begin
        sum_idx <= sum_idx + 1'b1;
      end
      if (cmd.div_init) begin
        div_cnt <= '0;
      end else if (cmd.div_step) begin
        div_cnt <= div_cnt + 1'b1;
      end
      if (cmd.eval) begin
        quiet_run         <= quiet_next;
        occupied_flag     <= occ_next;
        previous_occupied <= occ_next;
        seen_first        <= 1'b1;
        pend_temp         <= temp_hit;
        pend_occ          <= seen_first && changed;
        pend_rep          <= report;
        if (report) begin
          sent_once        <= 1'b1;
          sent_temperature <= t_avg;
          sent_humidity    <= h_avg;
          sent_light       <= l_avg;
          skipped_reports  <= '0;
        end else if (skipped_reports != snc_pkg::COUNT_MAX) begin
          skipped_reports <= skipped_reports + 8'd1;
        end
      end else if (out_load) begin
        if (pend_temp) begin
          pend_temp <= 1'b0;
        end else if (pend_occ) begin
          pend_occ <= 1'b0;
        end else begin
          pend_rep <= 1'b0;
        end
      end
    end
  end

  // Output register: results leave one per transaction in priority order.
  assign out_load = cmd.emit && !status.emit_done && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_avg_temperature <= t_avg;
      out_avg_humidity    <= h_avg;
      out_avg_light       <= l_avg;
      out_occupied        <= occupied_flag;
      if (pend_temp) begin
        out_kind        <= snc_pkg::KIND_TEMP_ALERT;
        out_alert_value <= temp_abs;
        out_last        <= !(pend_occ || pend_rep);
      end else if (pend_occ) begin
        out_kind        <= snc_pkg::KIND_OCC_ALERT;
        out_alert_value <= {13'd0, occupied_flag};
        out_last        <= !pend_rep;
      end else begin
        out_kind        <= snc_pkg::KIND_REPORT;
        out_alert_value <= '0;
        out_last        <= 1'b1;
      end
    end
  end

endmodule
